[rtl/core/uartrb_pkg.sv]
// shared types and constants for the dual serial-port ring buffers
`default_nettype none

package uartrb_pkg;

  localparam int RING_DEPTH_DEF = 128;
  localparam int PORT_COUNT_DEF = 2;

  typedef enum logic [1:0] {
    CMD_LINE_BYTE = 2'd0,
    CMD_HOST_GET  = 2'd1,
    CMD_HOST_PUT  = 2'd2,
    CMD_TX_READY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] command;
    logic       port;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic [7:0] rx_count;
    logic [7:0] tx_count;
    logic       tx_irq_enable;
  } out_item_t;

  // request into one ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_req_t;

  // condition of the selected ring before the request
  typedef struct packed {
    logic full;
    logic empty;
  } ring_sta_t;

endpackage

`default_nettype wire

[rtl/core/uartrb_ring.sv]
// one ring per port in a shared byte memory, with per-port pointers and fill counts
`default_nettype none

module uartrb_ring import uartrb_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int PORT_COUNT = PORT_COUNT_DEF,
  localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1,
  localparam int CNT_W  = $clog2(RING_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [PORT_W-1:0] sel,
  input  wire ring_req_t         req,
  input  wire logic [7:0]        wdata,
  output      ring_sta_t         sta,
  output      logic [CNT_W-1:0]  fill_after,
  output      logic [7:0]        rdata
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int ADDR_W = $clog2(PORT_COUNT * RING_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_A   = (ADDR_W + 1)'(RING_DEPTH);

  logic [7:0]       store_r [PORT_COUNT * RING_DEPTH];
  logic [PTR_W-1:0] rp_r    [PORT_COUNT];
  logic [PTR_W-1:0] wp_r    [PORT_COUNT];
  logic [CNT_W-1:0] fill_r  [PORT_COUNT];
  logic [7:0]       rdata_r;

  logic [CNT_W-1:0]  cur_fill;
  logic [PTR_W-1:0]  cur_rp;
  logic [PTR_W-1:0]  cur_wp;
  logic [PTR_W-1:0]  rp_nxt;
  logic [PTR_W-1:0]  wp_nxt;
  logic              full;
  logic              empty;
  logic              push_ok;
  logic              pop_ok;
  logic [ADDR_W:0]   base;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  always_comb begin
    cur_fill   = fill_r[sel];
    cur_rp     = rp_r[sel];
    cur_wp     = wp_r[sel];
    full       = (cur_fill == DEPTH_CNT);
    empty      = (cur_fill == '0);
    push_ok    = req.push && !full;
    pop_ok     = req.pop && !empty;
    rp_nxt     = (cur_rp == PTR_LAST) ? '0 : cur_rp + 1'b1;
    wp_nxt     = (cur_wp == PTR_LAST) ? '0 : cur_wp + 1'b1;
    fill_after = cur_fill + CNT_W'(push_ok) - CNT_W'(pop_ok);
    base       = (ADDR_W + 1)'(sel) * DEPTH_A;
    waddr      = ADDR_W'(base + (ADDR_W + 1)'(cur_wp));
    raddr      = ADDR_W'(base + (ADDR_W + 1)'(cur_rp));
  end

  assign sta.full  = full;
  assign sta.empty = empty;
  assign rdata     = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        rp_r[i]   <= '0;
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (push_ok) begin
        wp_r[sel] <= wp_nxt;
      end
      if (pop_ok) begin
        rp_r[sel] <= rp_nxt;
      end
      if (push_ok || pop_ok) begin
        fill_r[sel] <= fill_after;
      end
    end
  end

  // byte memory, registered read
  always_ff @(posedge clk) begin
    if (push_ok) begin
      store_r[waddr] <= wdata;
    end
    if (pop_ok) begin
      rdata_r <= store_r[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/dual_uart_ring_buffers.sv]
// top level: receive and transmit rings for each serial port with host and line access
`default_nettype none

// Each of PORT_COUNT serial ports owns a receive ring and a transmit ring of
// RING_DEPTH bytes. A transaction on the input channel carries one command:
// a line byte received (appended to the receive ring, dropped when full), a
// host get (pops the oldest received byte), a host put (appended to the
// transmit ring, sets that port's transmit-ready interrupt enable) or a
// transmitter-ready event (pops the next byte to send, clears the enable once
// the ring is empty). Every input transaction yields exactly one output
// transaction with the popped byte, a status (ok, full, empty) and the
// selected port's ring counts and enable after the command. The block takes
// one transaction per cycle unless a stalled output holds it up; a result
// passes through the input register, then the ring update together with the
// registered read of the ring memory loads the result register, from which
// it is presented. Each ring direction is one memory with one write and one
// registered read per cycle, which sets that rate. The ring memories need no
// clearing after reset; only pointers, fill counts and enables are reset. A
// port number at or above PORT_COUNT is ignored and returns an all-zero result.
module dual_uart_ring_buffers import uartrb_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int PORT_COUNT = PORT_COUNT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data
);

  localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam logic [3:0] PORT_COUNT_C = 4'(PORT_COUNT);

  // input register stage
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;

  // result register stage
  logic       s2_valid_r, s2_valid_nxt;
  status_t    res_status_r;
  logic [7:0] res_rx_cnt_r;
  logic [7:0] res_tx_cnt_r;
  logic       res_en_r;
  logic       pop_rx_r;
  logic       pop_tx_r;

  // per-port transmit-ready interrupt enables
  logic en_r [PORT_COUNT];

  logic              s2_load;
  logic              fire;
  logic              in_acc;
  logic              port_ok;
  logic              act;
  logic [PORT_W-1:0] sel;
  ring_req_t         rx_req;
  ring_req_t         tx_req;
  ring_sta_t         rx_sta;
  ring_sta_t         tx_sta;
  logic [CNT_W-1:0]  rx_fill_after;
  logic [CNT_W-1:0]  tx_fill_after;
  logic [7:0]        rx_rdata;
  logic [7:0]        tx_rdata;
  logic              en_cur;
  logic              en_after;
  status_t           status;

  // handshake: result register frees when empty or taken this cycle
  always_comb begin
    s2_load      = !s2_valid_r || !out_stall;
    fire         = s1_valid_r && s2_load;
    in_stall     = s1_valid_r && !s2_load;
    in_acc       = in_valid && !in_stall;
    s1_valid_nxt = in_acc ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s2_load ? fire : s2_valid_r;
  end

  // command decode for the item leaving the input register
  always_comb begin
    port_ok = ({3'b000, s1_item_r.port} < PORT_COUNT_C);
    sel     = PORT_W'(s1_item_r.port);
    act     = fire && port_ok;

    rx_req.push = act && (s1_item_r.command == CMD_LINE_BYTE);
    rx_req.pop  = act && (s1_item_r.command == CMD_HOST_GET);
    tx_req.push = act && (s1_item_r.command == CMD_HOST_PUT);
    tx_req.pop  = act && (s1_item_r.command == CMD_TX_READY);

    en_cur = en_r[sel];
    case (s1_item_r.command)
      CMD_LINE_BYTE: begin
        status   = rx_sta.full ? ST_FULL : ST_OK;
        en_after = en_cur;
      end
      CMD_HOST_GET: begin
        status   = rx_sta.empty ? ST_EMPTY : ST_OK;
        en_after = en_cur;
      end
      CMD_HOST_PUT: begin
        // a refused put leaves the enable alone
        status   = tx_sta.full ? ST_FULL : ST_OK;
        en_after = en_cur || !tx_sta.full;
      end
      CMD_TX_READY: begin
        // cleared whenever the ring ends up empty, also on an empty event
        status   = tx_sta.empty ? ST_EMPTY : ST_OK;
        en_after = en_cur && (tx_fill_after != '0);
      end
      default: begin
        status   = ST_OK;
        en_after = en_cur;
      end
    endcase
  end

  uartrb_ring #(
    .RING_DEPTH (RING_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_rx_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .sel        (sel),
    .req        (rx_req),
    .wdata      (s1_item_r.data_byte),
    .sta        (rx_sta),
    .fill_after (rx_fill_after),
    .rdata      (rx_rdata)
  );

  uartrb_ring #(
    .RING_DEPTH (RING_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_tx_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .sel        (sel),
    .req        (tx_req),
    .wdata      (s1_item_r.data_byte),
    .sta        (tx_sta),
    .fill_after (tx_fill_after),
    .rdata      (tx_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      pop_rx_r   <= 1'b0;
      pop_tx_r   <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        en_r[i] <= 1'b0;
      end
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (fire) begin
        pop_rx_r <= rx_req.pop && !rx_sta.empty;
        pop_tx_r <= tx_req.pop && !tx_sta.empty;
      end
      if (act) begin
        en_r[sel] <= en_after;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      res_status_r <= port_ok ? status : ST_OK;
      res_rx_cnt_r <= port_ok ? 8'(rx_fill_after) : 8'h00;
      res_tx_cnt_r <= port_ok ? 8'(tx_fill_after) : 8'h00;
      res_en_r     <= port_ok && en_after;
    end
  end

  // popped byte comes straight from the registered memory read
  always_comb begin
    out_valid              = s2_valid_r;
    out_data.data_out      = pop_rx_r ? rx_rdata : (pop_tx_r ? tx_rdata : 8'h00);
    out_data.status        = res_status_r;
    out_data.rx_count      = res_rx_cnt_r;
    out_data.tx_count      = res_tx_cnt_r;
    out_data.tx_irq_enable = res_en_r;
  end

endmodule

`default_nettype wire

[rtl/core/uartrb_checker.sv]
// port-level checks for the ring buffer top level, bound to it
`default_nettype none

module uartrb_checker import uartrb_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  localparam logic [7:0] DEPTH_LOW = 8'(RING_DEPTH);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |->
      (out_data.rx_count == DEPTH_LOW) || (out_data.tx_count == DEPTH_LOW))
    else $error("full status without a full ring");

  a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |->
      (out_data.data_out == 8'h00) &&
      ((out_data.rx_count == 8'h00) || (out_data.tx_count == 8'h00)))
    else $error("empty status with data or without an empty ring");

endmodule

bind dual_uart_ring_buffers uartrb_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_uartrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
